@@ rtl/core/gcd_pkg.sv @@
`default_nettype none

package gcd_pkg;

	localparam int SLOT_W      = 4;
	localparam int CNT_W       = 8;
	localparam int REAIS_W     = 16;
	localparam int CENT_W      = 7;
	localparam int AMT_W       = 23;
	localparam int DEN_W       = 7;
	localparam int DIV_W       = 15;
	localparam int RECIP_W     = 23;
	localparam int RECIP_SHIFT = 22;

	typedef logic [DEN_W-1:0] denom_t;

	localparam denom_t NOTE_VALUE [8] = '{
		DEN_W'(100), DEN_W'(50), DEN_W'(20), DEN_W'(10),
		DEN_W'(5), DEN_W'(2), DEN_W'(0), DEN_W'(0)
	};
	localparam denom_t COIN_VALUE [8] = '{
		DEN_W'(100), DEN_W'(50), DEN_W'(25), DEN_W'(10),
		DEN_W'(5), DEN_W'(1), DEN_W'(0), DEN_W'(0)
	};

	// ceil(2^22 / d), exact for dividends below 2^15
	function automatic logic [RECIP_W-1:0] recip_of(input denom_t d);
		logic [RECIP_W-1:0] r;
		unique case (d)
			DEN_W'(100): r = RECIP_W'(41944);
			DEN_W'(50):  r = RECIP_W'(83887);
			DEN_W'(25):  r = RECIP_W'(167773);
			DEN_W'(20):  r = RECIP_W'(209716);
			DEN_W'(10):  r = RECIP_W'(419431);
			DEN_W'(5):   r = RECIP_W'(838861);
			DEN_W'(2):   r = RECIP_W'(2097152);
			DEN_W'(1):   r = RECIP_W'(4194304);
			default:     r = '0;
		endcase
		return r;
	endfunction

	typedef enum logic [0:0] {
		FUNC_CHANGE = 1'b0,
		FUNC_LOAD   = 1'b1
	} func_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [CNT_W-1:0]  data;
	} mem_wr_t;

	typedef struct packed {
		logic             start;
		logic [AMT_W-1:0] amount;
		logic [CNT_W-1:0] have;
		denom_t           denom;
	} pay_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] want;
		logic [AMT_W-1:0] rest;
	} pay_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/greedy_change_dispenser.sv @@
`default_nettype none

// Change dispenser with a stock count per slot, notes first then coins. A load
// request writes the stock memory directly and gives no result. A change
// request walks the slots in order through one read-modify-write of the stock
// memory each: a slot takes the short path through S_CHK, S_PAY and S_WB when
// it pays out its whole stock or nothing, and stays longer in S_PAY when a
// reciprocal multiply and a multiply-subtract must find how many units fit the
// remaining amount, and S_WB waits while the output side stalls. With twelve
// slots the twelfth result carries last and the unpaid amount in centavos. A
// new request is taken once the final result has been registered, and the
// stock memory needs no clearing after reset.
module greedy_change_dispenser #(
	parameter int NOTE_SLOTS = 6,
	parameter int COIN_SLOTS = 6
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire                           func,
	input  wire [gcd_pkg::REAIS_W-1:0]    reais,
	input  wire [gcd_pkg::CENT_W-1:0]     centavos,
	input  wire [gcd_pkg::SLOT_W-1:0]     slot,
	input  wire [gcd_pkg::CNT_W-1:0]      stock_count,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [gcd_pkg::SLOT_W-1:0]    out_slot,
	output logic [gcd_pkg::CNT_W-1:0]     dispensed,
	output logic [gcd_pkg::AMT_W-1:0]     shortfall,
	output logic                          last
);

	localparam int TOTAL = NOTE_SLOTS + COIN_SLOTS;
	localparam int AW    = $clog2(TOTAL);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CHK  = 4'b0010,
		S_PAY  = 4'b0100,
		S_WB   = 4'b1000
	} state_t;

	state_t                           state_q;
	logic [gcd_pkg::SLOT_W-1:0]       idx_q;
	logic [gcd_pkg::AMT_W-1:0]        amount_q;
	logic [gcd_pkg::CENT_W-1:0]       cents_q;
	logic                             out_valid_q;
	logic [gcd_pkg::SLOT_W-1:0]       out_slot_q;
	logic [gcd_pkg::CNT_W-1:0]        dispensed_q;
	logic [gcd_pkg::AMT_W-1:0]        shortfall_q;
	logic                             last_q;

	gcd_pkg::mem_wr_t                 mem_wr;
	logic                             rd_en;
	logic [AW-1:0]                    rd_addr;
	logic [gcd_pkg::CNT_W-1:0]        have;
	gcd_pkg::pay_req_t                pay_req;
	gcd_pkg::pay_rsp_t                pay_rsp;
	gcd_pkg::denom_t                  denom;
	logic [gcd_pkg::SLOT_W-1:0]       coin_idx;
	logic                             is_load;
	logic                             is_last;
	logic                             proceed;
	logic [gcd_pkg::AMT_W-1:0]        scaled;
	logic [gcd_pkg::AMT_W-1:0]        next_amt;

	gcd_stock_mem #(
		.DEPTH (TOTAL),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (have)
	);

	gcd_pay_unit u_pay (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pay_req),
		.rsp    (pay_rsp)
	);

	assign coin_idx = idx_q - gcd_pkg::SLOT_W'(NOTE_SLOTS);
	assign denom    = (idx_q < gcd_pkg::SLOT_W'(NOTE_SLOTS)) ?
		gcd_pkg::NOTE_VALUE[idx_q[2:0]] : gcd_pkg::COIN_VALUE[coin_idx[2:0]];

	assign is_load  = (gcd_pkg::func_t'(func) == gcd_pkg::FUNC_LOAD);
	assign is_last  = (idx_q == gcd_pkg::SLOT_W'(TOTAL - 1));
	assign proceed  = (state_q == S_WB) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE);

	// leftover reais move into the coin amount after the last note
	assign scaled   = gcd_pkg::AMT_W'(32'(pay_rsp.rest) * 32'd100)
		+ gcd_pkg::AMT_W'(cents_q);
	assign next_amt = (idx_q == gcd_pkg::SLOT_W'(NOTE_SLOTS - 1)) ? scaled : pay_rsp.rest;

	always_comb begin
		mem_wr.en   = 1'b0;
		mem_wr.addr = idx_q;
		mem_wr.data = have - pay_rsp.want;
		rd_en       = 1'b0;
		rd_addr     = '0;
		if (state_q == S_IDLE && in_valid) begin
			if (is_load) begin
				mem_wr.en   = ({1'b0, slot} < (gcd_pkg::SLOT_W + 1)'(TOTAL));
				mem_wr.addr = slot;
				mem_wr.data = stock_count;
			end else begin
				rd_en = 1'b1;
			end
		end else if (proceed) begin
			mem_wr.en = 1'b1;
			rd_en     = !is_last;
			rd_addr   = AW'(idx_q + 1'b1);
		end
	end

	always_comb begin
		pay_req.start  = (state_q == S_CHK);
		pay_req.amount = amount_q;
		pay_req.have   = have;
		pay_req.denom  = denom;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !is_load) begin
			amount_q <= gcd_pkg::AMT_W'(reais);
			cents_q  <= centavos;
			idx_q    <= '0;
		end else if (proceed) begin
			amount_q    <= next_amt;
			idx_q       <= idx_q + 1'b1;
			out_slot_q  <= idx_q;
			dispensed_q <= pay_rsp.want;
			shortfall_q <= is_last ? pay_rsp.rest : '0;
			last_q      <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (proceed) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !is_load) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= S_PAY;
				end
				S_PAY: begin
					if (pay_rsp.done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (proceed) begin
						state_q <= is_last ? S_IDLE : S_CHK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_slot  = out_slot_q;
	assign dispensed = dispensed_q;
	assign shortfall = shortfall_q;
	assign last      = last_q;

`ifndef SYNTH
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_slot == gcd_pkg::SLOT_W'(TOTAL - 1))
		else $error("last result not on final slot");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> shortfall == '0)
		else $error("shortfall set on inner result");

	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last)
		else $error("request taken while results of previous one pending");

	a_pay_done: assert property (@(posedge clk) disable iff (!arst_n)
		pay_rsp.done |-> state_q == S_PAY && pay_rsp.want <= have)
		else $error("pay unit result outside pay state or above stock");
`endif

endmodule

`default_nettype wire

@@ rtl/core/gcd_stock_mem.sv @@
`default_nettype none

module gcd_stock_mem #(
	parameter int DEPTH = 12,
	parameter int AW    = 4
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire gcd_pkg::mem_wr_t   wr,
	input  wire                     rd_en,
	input  wire [AW-1:0]            rd_addr,
	output logic [gcd_pkg::CNT_W-1:0] rd_data
);

	logic [gcd_pkg::CNT_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]          vld_q;
	logic [gcd_pkg::CNT_W-1:0] rdata_q;
	logic                      rvld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// entries never loaded read as an empty slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/gcd_pay_unit.sv @@
`default_nettype none

module gcd_pay_unit (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire gcd_pkg::pay_req_t req,
	output gcd_pkg::pay_rsp_t      rsp
);

	localparam int QP_W = gcd_pkg::DIV_W + gcd_pkg::RECIP_W;

	logic [gcd_pkg::AMT_W-1:0]   rem_q;
	logic [gcd_pkg::CNT_W-1:0]   quo_q;
	gcd_pkg::denom_t             denom_q;
	logic                        run_q;
	logic                        step_q;
	logic                        done_q;
	logic [gcd_pkg::AMT_W-1:0]   prod;
	logic [gcd_pkg::RECIP_W-1:0] recip;
	logic [QP_W-1:0]             qprod;

	// full stock fits the amount when amount >= have * denom
	assign prod  = gcd_pkg::AMT_W'(req.have) * gcd_pkg::AMT_W'(req.denom);
	// otherwise amount is below 255 * 100 and a reciprocal multiply gives the quotient
	assign recip = gcd_pkg::recip_of(denom_q);
	assign qprod = QP_W'(rem_q[gcd_pkg::DIV_W-1:0]) * QP_W'(recip);

	always_ff @(posedge clk) begin
		if (req.start) begin
			denom_q <= req.denom;
			if (req.denom == '0) begin
				quo_q <= '0;
				rem_q <= req.amount;
			end else if (req.amount >= prod) begin
				quo_q <= req.have;
				rem_q <= req.amount - prod;
			end else begin
				quo_q <= '0;
				rem_q <= req.amount;
			end
		end else if (run_q) begin
			if (!step_q) begin
				quo_q <= gcd_pkg::CNT_W'(qprod >> gcd_pkg::RECIP_SHIFT);
			end else begin
				rem_q <= rem_q - gcd_pkg::AMT_W'(quo_q) * gcd_pkg::AMT_W'(denom_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				step_q <= 1'b0;
				if (req.denom == '0 || req.amount >= prod) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				if (step_q) begin
					run_q  <= 1'b0;
					step_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.want = quo_q;
	assign rsp.rest = rem_q;

endmodule

`default_nettype wire
